/* rtl/lsmc_pkg.sv */
// shared types, codes and constant tables of the level-set mean-curvature engine
`default_nettype none

package lsmc_pkg;

    // operation codes of an input item
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    // neighborhood reads, in issue order
    localparam int RD_COUNT = 19;
    localparam logic [4:0] RD_C      = 5'd0;
    localparam logic [4:0] RD_XM     = 5'd1;
    localparam logic [4:0] RD_XP     = 5'd2;
    localparam logic [4:0] RD_YM     = 5'd3;
    localparam logic [4:0] RD_YP     = 5'd4;
    localparam logic [4:0] RD_ZM     = 5'd5;
    localparam logic [4:0] RD_ZP     = 5'd6;
    localparam logic [4:0] RD_XY_MM  = 5'd7;
    localparam logic [4:0] RD_XY_PP  = 5'd8;
    localparam logic [4:0] RD_XY_PM  = 5'd9;
    localparam logic [4:0] RD_XY_MP  = 5'd10;
    localparam logic [4:0] RD_XZ_MM  = 5'd11;
    localparam logic [4:0] RD_XZ_PP  = 5'd12;
    localparam logic [4:0] RD_XZ_PM  = 5'd13;
    localparam logic [4:0] RD_XZ_MP  = 5'd14;
    localparam logic [4:0] RD_YZ_MM  = 5'd15;
    localparam logic [4:0] RD_YZ_PP  = 5'd16;
    localparam logic [4:0] RD_YZ_PM  = 5'd17;
    localparam logic [4:0] RD_YZ_MP  = 5'd18;
    localparam logic [4:0] RD_LAST   = 5'd19;

    // multiply sequence: squares, pair products, then numerator terms
    localparam logic [3:0] MOP_SQ_X = 4'd0;
    localparam logic [3:0] MOP_SQ_Y = 4'd1;
    localparam logic [3:0] MOP_SQ_Z = 4'd2;
    localparam logic [3:0] MOP_P_XY = 4'd3;
    localparam logic [3:0] MOP_P_XZ = 4'd4;
    localparam logic [3:0] MOP_P_YZ = 4'd5;
    localparam logic [3:0] MOP_T_X  = 4'd6;
    localparam logic [3:0] MOP_T_Y  = 4'd7;
    localparam logic [3:0] MOP_T_Z  = 4'd8;
    localparam logic [3:0] MOP_C_XY = 4'd9;
    localparam logic [3:0] MOP_C_XZ = 4'd10;
    localparam logic [3:0] MOP_C_YZ = 4'd11;

    // quotient bits of the divider
    localparam int QW = 32;
    localparam logic [4:0] DIV_LAST = 5'd31;

    // digit width of the shared multiplier
    localparam int DIGIT_W = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DERIV,
        ST_MUL_LOAD,
        ST_MUL_STEP,
        ST_MUL_WB,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DONE
    } lsmc_state_t;

    typedef struct packed {
        logic       mem_write;
        logic       load_item;
        logic       rd_issue;
        logic [4:0] rd_idx;
        logic       deriv;
        logic       mul_load;
        logic       mul_step;
        logic       mul_wb;
        logic [3:0] op_idx;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } lsmc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } lsmc_stat_t;

    typedef struct packed {
        logic signed [1:0] ox;
        logic signed [1:0] oy;
        logic signed [1:0] oz;
    } lsmc_off_t;

    // voxel offset of each neighborhood read
    function automatic lsmc_off_t rd_offset(input logic [4:0] idx);
        lsmc_off_t o;
        o = '{ox: 2'sd0, oy: 2'sd0, oz: 2'sd0};
        unique case (idx)
            RD_XM:    o.ox = -2'sd1;
            RD_XP:    o.ox = 2'sd1;
            RD_YM:    o.oy = -2'sd1;
            RD_YP:    o.oy = 2'sd1;
            RD_ZM:    o.oz = -2'sd1;
            RD_ZP:    o.oz = 2'sd1;
            RD_XY_MM: begin o.ox = -2'sd1; o.oy = -2'sd1; end
            RD_XY_PP: begin o.ox = 2'sd1;  o.oy = 2'sd1;  end
            RD_XY_PM: begin o.ox = 2'sd1;  o.oy = -2'sd1; end
            RD_XY_MP: begin o.ox = -2'sd1; o.oy = 2'sd1;  end
            RD_XZ_MM: begin o.ox = -2'sd1; o.oz = -2'sd1; end
            RD_XZ_PP: begin o.ox = 2'sd1;  o.oz = 2'sd1;  end
            RD_XZ_PM: begin o.ox = 2'sd1;  o.oz = -2'sd1; end
            RD_XZ_MP: begin o.ox = -2'sd1; o.oz = 2'sd1;  end
            RD_YZ_MM: begin o.oy = -2'sd1; o.oz = -2'sd1; end
            RD_YZ_PP: begin o.oy = 2'sd1;  o.oz = 2'sd1;  end
            RD_YZ_PM: begin o.oy = 2'sd1;  o.oz = -2'sd1; end
            RD_YZ_MP: begin o.oy = -2'sd1; o.oz = 2'sd1;  end
            default:  o = '{ox: 2'sd0, oy: 2'sd0, oz: 2'sd0};
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

/* rtl/level_set_mean_curvature_3d.sv */
// Mean-curvature engine over a 3D fixed-point level-set volume.
// Input items (s_valid/s_ready): s_operation selects a write of s_level_value
// into voxel (s_pos_x, s_pos_y, s_pos_z), or a curvature compute at that voxel.
// A write gives no result and the block stays ready; writes outside the store are dropped.
// A compute item returns one m_curvature item (signed Q25.7, saturated).
// A compute runs 19 serial reads through the single memory read port,
// twelve passes of the shared byte-serial multiplier and a 32-step
// restoring divider. One compute item is worked on at a time, and no new
// item is taken until its result has gone to the output register;
// writes go one per cycle while no compute is under way.
// Sizes are written through cfg_valid/cfg_index/cfg_data (always ready);
// the user must write them only while the block is idle, which the block
// itself does not enforce. Reset sets all sizes to 32 and empties the
// result register; the volume is not cleared and must be written before use.
// While the receiver stalls, the finished result waits in the output register
// and a new item is still taken; the next compute result waits in the engine
// until the register frees up.
`default_nettype none

module level_set_mean_curvature_3d
    import lsmc_pkg::*;
#(
    parameter int AXIS_SIZE   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [4:0]         s_pos_x,
    input  wire logic [4:0]         s_pos_y,
    input  wire logic [4:0]         s_pos_z,
    input  wire logic signed [15:0] s_level_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_curvature,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [5:0]         cfg_data
);

    lsmc_cmd_t  cmd;
    lsmc_stat_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    lsmc_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .cmd         (cmd),
        .stat        (stat)
    );

    // datapath
    lsmc_dpath #(
        .AXIS_SIZE   (AXIS_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_level_value (s_level_value),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_curvature   (m_curvature)
    );

endmodule

`default_nettype wire

/* rtl/lsmc_ctrl.sv */
// sequencer for item intake, neighborhood reads, multiply passes and division
`default_nettype none

module lsmc_ctrl
    import lsmc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_operation,
    output lsmc_cmd_t       cmd,
    input  wire lsmc_stat_t stat
);

    localparam int ND  = (VALUE_WIDTH + 1 + DIGIT_W - 1) / DIGIT_W;
    localparam int DGW = (ND > 1) ? $clog2(ND) : 1;

    lsmc_state_t      state_reg, state_next;
    logic [4:0]       rd_cnt_reg, rd_cnt_next;
    logic [3:0]       op_cnt_reg, op_cnt_next;
    logic [DGW-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [4:0]       div_cnt_reg, div_cnt_next;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            op_cnt_reg  <= '0;
            dig_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            op_cnt_reg  <= op_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept && s_operation == OP_COMPUTE) state_next = ST_READ;
            ST_READ:     if (rd_cnt_reg == RD_LAST) state_next = ST_DERIV;
            ST_DERIV:    state_next = ST_MUL_LOAD;
            ST_MUL_LOAD: state_next = ST_MUL_STEP;
            ST_MUL_STEP: if (dig_cnt_reg == DGW'(ND - 1)) state_next = ST_MUL_WB;
            ST_MUL_WB: begin
                if (op_cnt_reg == MOP_C_YZ) state_next = ST_DIV_INIT;
                else                        state_next = ST_MUL_LOAD;
            end
            ST_DIV_INIT: state_next = ST_DIV_STEP;
            ST_DIV_STEP: if (div_cnt_reg == DIV_LAST) state_next = ST_DONE;
            ST_DONE:     if (!stat.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb begin
        rd_cnt_next  = rd_cnt_reg;
        op_cnt_next  = op_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:     rd_cnt_next = '0;
            ST_READ:     rd_cnt_next = rd_cnt_reg + 5'd1;
            ST_DERIV:    op_cnt_next = MOP_SQ_X;
            ST_MUL_LOAD: dig_cnt_next = '0;
            ST_MUL_STEP: dig_cnt_next = dig_cnt_reg + DGW'(1);
            ST_MUL_WB:   op_cnt_next = op_cnt_reg + 4'd1;
            ST_DIV_INIT: div_cnt_next = '0;
            ST_DIV_STEP: div_cnt_next = div_cnt_reg + 5'd1;
            ST_DONE:     rd_cnt_next = '0;
            default:     rd_cnt_next = '0;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd        = '0;
        cmd.rd_idx = rd_cnt_reg;
        cmd.op_idx = op_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.mem_write = accept && (s_operation == OP_WRITE);
                cmd.load_item = accept && (s_operation == OP_COMPUTE);
            end
            ST_READ:     cmd.rd_issue = (rd_cnt_reg != RD_LAST);
            ST_DERIV:    cmd.deriv    = 1'b1;
            ST_MUL_LOAD: cmd.mul_load = 1'b1;
            ST_MUL_STEP: cmd.mul_step = 1'b1;
            ST_MUL_WB:   cmd.mul_wb   = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV_STEP: cmd.div_step = 1'b1;
            ST_DONE:     cmd.out_load = !stat.out_busy;
            default:     cmd.mem_write = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/lsmc_dpath.sv */
// volume memory, neighborhood registers, shared multiplier, divider and output register
`default_nettype none

module lsmc_dpath
    import lsmc_pkg::*;
#(
    parameter int AXIS_SIZE   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lsmc_cmd_t           cmd,
    output lsmc_stat_t               stat,
    input  wire logic [4:0]          s_pos_x,
    input  wire logic [4:0]          s_pos_y,
    input  wire logic [4:0]          s_pos_z,
    input  wire logic signed [15:0]  s_level_value,
    input  wire logic                cfg_valid,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [5:0]          cfg_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_curvature
);

    localparam int VW    = VALUE_WIDTH;
    localparam int D1W   = VW + 1;
    localparam int D2W   = VW + 2;
    localparam int SQW   = 2 * VW + 2;
    localparam int SW    = SQW;
    localparam int AXW   = 2 * VW + 4;
    localparam int NW    = 3 * VW + 6;
    localparam int BMW   = VW + 1;
    localparam int DEPTH = AXIS_SIZE * AXIS_SIZE * AXIS_SIZE;
    localparam int ADW   = $clog2(DEPTH);
    localparam int CMPW  = (NW > SW + 25) ? NW : SW + 25;

    // configuration registers
    logic [5:0] size_x_reg, size_y_reg, size_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 6'd32;
            size_y_reg <= 6'd32;
            size_z_reg <= 6'd32;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default:    size_x_reg <= size_x_reg;
            endcase
        end
    end

    // volume memory
    logic [VW-1:0]  level_mem [DEPTH];
    logic [ADW-1:0] waddr, raddr;
    logic           w_ok;

    assign w_ok  = (32'(s_pos_x) < AXIS_SIZE) && (32'(s_pos_y) < AXIS_SIZE)
                && (32'(s_pos_z) < AXIS_SIZE);
    assign waddr = ADW'(s_pos_x) + ADW'(AXIS_SIZE) * ADW'(s_pos_y)
                 + ADW'(AXIS_SIZE * AXIS_SIZE) * ADW'(s_pos_z);

    always_ff @(posedge aclk) begin
        if (cmd.mem_write && w_ok) level_mem[waddr] <= VW'(s_level_value);
    end

    // item latch and axis usability
    logic [4:0] px_reg, py_reg, pz_reg;
    logic       xok_reg, yok_reg, zok_reg;
    logic [5:0] px1, py1, pz1;

    assign px1 = {1'b0, s_pos_x} + 6'd1;
    assign py1 = {1'b0, s_pos_y} + 6'd1;
    assign pz1 = {1'b0, s_pos_z} + 6'd1;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            pz_reg  <= s_pos_z;
            xok_reg <= (s_pos_x != 5'd0) && (px1 < size_x_reg) && (32'(px1) < AXIS_SIZE);
            yok_reg <= (s_pos_y != 5'd0) && (py1 < size_y_reg) && (32'(py1) < AXIS_SIZE);
            zok_reg <= (s_pos_z != 5'd0) && (pz1 < size_z_reg) && (32'(pz1) < AXIS_SIZE);
        end
    end

    // neighborhood read address
    lsmc_off_t        off;
    logic signed [6:0] cx, cy, cz;
    logic              rng;

    assign off = rd_offset(cmd.rd_idx);
    assign cx  = $signed({2'b00, px_reg}) + 7'(off.ox);
    assign cy  = $signed({2'b00, py_reg}) + 7'(off.oy);
    assign cz  = $signed({2'b00, pz_reg}) + 7'(off.oz);
    assign rng = !cx[6] && !cy[6] && !cz[6] && (32'(cx[5:0]) < AXIS_SIZE)
              && (32'(cy[5:0]) < AXIS_SIZE) && (32'(cz[5:0]) < AXIS_SIZE);
    assign raddr = ADW'(cx[5:0]) + ADW'(AXIS_SIZE) * ADW'(cy[5:0])
                 + ADW'(AXIS_SIZE * AXIS_SIZE) * ADW'(cz[5:0]);

    // registered memory read
    logic [VW-1:0] rd_data_reg;
    logic [4:0]    rd_idx_reg;
    logic          rd_rng_reg;
    logic          rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= level_mem[raddr];
            rd_idx_reg  <= cmd.rd_idx;
            rd_rng_reg  <= rng;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) rd_vld_reg <= 1'b0;
        else          rd_vld_reg <= cmd.rd_issue;
    end

    // neighborhood values, out-of-store reads count as zero
    logic signed [VW-1:0] nb_reg [RD_COUNT];

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) nb_reg[rd_idx_reg] <= rd_rng_reg ? $signed(rd_data_reg) : '0;
    end

    // differences
    logic signed [D1W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [D2W-1:0] dxx_reg, dyy_reg, dzz_reg;
    logic signed [D2W-1:0] cxy_reg, cxz_reg, cyz_reg;
    logic signed [D2W-1:0] c2;

    assign c2 = D2W'(nb_reg[RD_C]) <<< 1;

    always_ff @(posedge aclk) begin
        if (cmd.deriv) begin
            dx_reg  <= xok_reg ? D1W'(nb_reg[RD_XM]) - D1W'(nb_reg[RD_XP]) : '0;
            dy_reg  <= yok_reg ? D1W'(nb_reg[RD_YM]) - D1W'(nb_reg[RD_YP]) : '0;
            dz_reg  <= zok_reg ? D1W'(nb_reg[RD_ZM]) - D1W'(nb_reg[RD_ZP]) : '0;
            dxx_reg <= xok_reg ? D2W'(nb_reg[RD_XM]) + D2W'(nb_reg[RD_XP]) - c2 : '0;
            dyy_reg <= yok_reg ? D2W'(nb_reg[RD_YM]) + D2W'(nb_reg[RD_YP]) - c2 : '0;
            dzz_reg <= zok_reg ? D2W'(nb_reg[RD_ZM]) + D2W'(nb_reg[RD_ZP]) - c2 : '0;
            cxy_reg <= (xok_reg && yok_reg)
                ? D2W'(nb_reg[RD_XY_MM]) + D2W'(nb_reg[RD_XY_PP])
                  - D2W'(nb_reg[RD_XY_PM]) - D2W'(nb_reg[RD_XY_MP]) : '0;
            cxz_reg <= (xok_reg && zok_reg)
                ? D2W'(nb_reg[RD_XZ_MM]) + D2W'(nb_reg[RD_XZ_PP])
                  - D2W'(nb_reg[RD_XZ_PM]) - D2W'(nb_reg[RD_XZ_MP]) : '0;
            cyz_reg <= (yok_reg && zok_reg)
                ? D2W'(nb_reg[RD_YZ_MM]) + D2W'(nb_reg[RD_YZ_PP])
                  - D2W'(nb_reg[RD_YZ_PM]) - D2W'(nb_reg[RD_YZ_MP]) : '0;
        end
    end

    // products kept between multiply passes
    logic signed [SQW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [SQW-1:0] pxy_reg, pxz_reg, pyz_reg;
    logic signed [NW-1:0]  num_reg;

    // operand selection for the shared multiplier
    logic signed [NW-1:0]  a_val;
    logic signed [D2W-1:0] b_val;
    logic                  sub_op;
    logic                  flip;
    logic [BMW-1:0]        b_mag;

    always_comb begin
        a_val  = '0;
        b_val  = '0;
        sub_op = 1'b0;
        unique case (cmd.op_idx)
            MOP_SQ_X: begin a_val = NW'(dx_reg); b_val = D2W'(dx_reg); end
            MOP_SQ_Y: begin a_val = NW'(dy_reg); b_val = D2W'(dy_reg); end
            MOP_SQ_Z: begin a_val = NW'(dz_reg); b_val = D2W'(dz_reg); end
            MOP_P_XY: begin a_val = NW'(dx_reg); b_val = D2W'(dy_reg); end
            MOP_P_XZ: begin a_val = NW'(dx_reg); b_val = D2W'(dz_reg); end
            MOP_P_YZ: begin a_val = NW'(dy_reg); b_val = D2W'(dz_reg); end
            MOP_T_X: begin
                a_val = NW'((AXW'(sy_reg) + AXW'(sz_reg)) <<< 1);
                b_val = dxx_reg;
            end
            MOP_T_Y: begin
                a_val = NW'((AXW'(sx_reg) + AXW'(sz_reg)) <<< 1);
                b_val = dyy_reg;
            end
            MOP_T_Z: begin
                a_val = NW'((AXW'(sx_reg) + AXW'(sy_reg)) <<< 1);
                b_val = dzz_reg;
            end
            MOP_C_XY: begin a_val = NW'(pxy_reg); b_val = cxy_reg; sub_op = 1'b1; end
            MOP_C_XZ: begin a_val = NW'(pxz_reg); b_val = cxz_reg; sub_op = 1'b1; end
            MOP_C_YZ: begin a_val = NW'(pyz_reg); b_val = cyz_reg; sub_op = 1'b1; end
            default:  begin a_val = '0; b_val = '0; end
        endcase
    end

    assign flip  = b_val[D2W-1] ^ sub_op;
    assign b_mag = b_val[D2W-1] ? BMW'(-b_val) : BMW'(b_val);

    // digit-serial multiply, one byte of the magnitude per cycle
    logic signed [NW-1:0] a_sh_reg;
    logic [BMW-1:0]       b_reg;
    logic signed [NW-1:0] acc_reg;
    logic signed [NW-1:0] part;

    assign part = NW'(a_sh_reg * $signed({1'b0, b_reg[DIGIT_W-1:0]}));

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            a_sh_reg <= flip ? -a_val : a_val;
            b_reg    <= b_mag;
            acc_reg  <= '0;
        end else if (cmd.mul_step) begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= a_sh_reg <<< DIGIT_W;
            b_reg    <= b_reg >> DIGIT_W;
        end
    end

    // product write-back
    always_ff @(posedge aclk) begin
        if (cmd.deriv) begin
            num_reg <= '0;
        end else if (cmd.mul_wb) begin
            case (cmd.op_idx)
                MOP_SQ_X: sx_reg  <= SQW'(acc_reg);
                MOP_SQ_Y: sy_reg  <= SQW'(acc_reg);
                MOP_SQ_Z: sz_reg  <= SQW'(acc_reg);
                MOP_P_XY: pxy_reg <= SQW'(acc_reg);
                MOP_P_XZ: pxz_reg <= SQW'(acc_reg);
                MOP_P_YZ: pyz_reg <= SQW'(acc_reg);
                default:  num_reg <= num_reg + acc_reg;
            endcase
        end
    end

    // restoring division of |num| * 128 by the gradient square
    logic [SW-1:0]  s_sum;
    logic [NW-1:0]  mag;
    logic [SW-1:0]  s_reg;
    logic [SW-1:0]  rem_reg;
    logic [QW-1:0]  dvd_reg;
    logic [QW-1:0]  q_reg;
    logic           neg_reg, sat_reg, zero_reg;
    logic [SW:0]    r2;

    assign s_sum = $unsigned(sx_reg) + $unsigned(sy_reg) + $unsigned(sz_reg);
    assign mag   = num_reg[NW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign r2    = {rem_reg, dvd_reg[QW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            s_reg    <= s_sum;
            zero_reg <= (s_sum == '0);
            neg_reg  <= num_reg[NW-1];
            sat_reg  <= CMPW'(mag) >= (CMPW'(s_sum) << 25);
            rem_reg  <= SW'(mag >> 25);
            dvd_reg  <= {mag[24:0], 7'b0};
            q_reg    <= '0;
        end else if (cmd.div_step) begin
            if (r2 >= {1'b0, s_reg}) begin
                rem_reg <= SW'(r2 - {1'b0, s_reg});
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= SW'(r2);
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
            dvd_reg <= dvd_reg << 1;
        end
    end

    // signed saturation of the quotient
    logic [QW:0]        q_full, q_lim;
    logic signed [31:0] curv_next;

    assign q_full = sat_reg ? {1'b1, {QW{1'b0}}} : {1'b0, q_reg};

    always_comb begin
        if (neg_reg) begin
            q_lim = (q_full > 33'h0_8000_0000) ? 33'h0_8000_0000 : q_full;
            curv_next = $signed(-q_lim[31:0]);
        end else begin
            q_lim = (q_full > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : q_full;
            curv_next = $signed(q_lim[31:0]);
        end
        if (zero_reg) curv_next = '0;
    end

    // output register
    logic               m_valid_reg;
    logic signed [31:0] m_curv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_curv_reg <= curv_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_curvature   = m_curv_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

endmodule

`default_nettype wire

/* rtl/lsmc_check.sv */
// port-level checks of the curvature engine, bound to the top level
`default_nettype none

module lsmc_check
    import lsmc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_operation,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_curvature
);

    // result register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item present after reset");

    // a compute item keeps the engine busy on the next cycle
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_COMPUTE) |=> !s_ready)
        else $error("new item taken right after a compute item");

    // after a write item the engine is ready again in the next cycle
    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_WRITE) |=> s_ready)
        else $error("write item did not finish in one cycle");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_curvature)))
        else $error("stalled result item changed");

endmodule

bind level_set_mean_curvature_3d lsmc_check u_lsmc_check (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_curvature (m_curvature)
);

`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for the level-set mean-curvature engine
`default_nettype none

module tb;
    import lsmc_pkg::*;

    localparam int  NVOX       = 32 * 32 * 32;
    localparam int  FILL       = 6;
    localparam int  DRAIN_WAIT = 160;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic              op;
        logic [4:0]        x;
        logic [4:0]        y;
        logic [4:0]        z;
        logic signed [15:0] v;
        bit                known;
        logic [31:0]       k;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_operation = OP_WRITE;
    logic [4:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [15:0] s_level_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_curvature;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_SIZE_X;
    logic [5:0] cfg_data = '0;

    // predictor state
    logic signed [15:0] level_mem [0:NVOX-1];
    bit written [0:NVOX-1];
    logic [5:0] sz_x = 6'd32, sz_y = 6'd32, sz_z = 6'd32;
    logic [31:0] curv_q[$];
    stim_row_t dir_tab[$];
    int fails = 0;
    int burst_left = 0;
    longint cyc = 0;
    int stall_pct = 0;

    level_set_mean_curvature_3d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_pos_z(s_pos_z), .s_level_value(s_level_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_curvature(m_curvature),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // voxel read, zero outside the store
    function automatic longint vox(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x > 31 || y > 31 || z > 31) return 0;
        return longint'(level_mem[x + 32 * (y + 32 * z)]);
    endfunction

    function automatic int eff_size(logic [5:0] s);
        return (s > 6'd32) ? 32 : int'(s);
    endfunction

    function automatic bit wr(int x, int y, int z);
        return written[x + 32 * (y + 32 * z)];
    endfunction

    // true when every voxel that a compute at this position uses has been written
    function automatic bit legal(int px, int py, int pz);
        bit xok, yok, zok;
        xok = px >= 1 && px + 1 < eff_size(sz_x);
        yok = py >= 1 && py + 1 < eff_size(sz_y);
        zok = pz >= 1 && pz + 1 < eff_size(sz_z);
        if (!(xok || yok || zok)) return 1'b1;
        if (!wr(px, py, pz)) return 1'b0;
        if (xok && !(wr(px-1, py, pz) && wr(px+1, py, pz))) return 1'b0;
        if (yok && !(wr(px, py-1, pz) && wr(px, py+1, pz))) return 1'b0;
        if (zok && !(wr(px, py, pz-1) && wr(px, py, pz+1))) return 1'b0;
        if (xok && yok && !(wr(px-1, py-1, pz) && wr(px+1, py+1, pz)
                && wr(px+1, py-1, pz) && wr(px-1, py+1, pz))) return 1'b0;
        if (xok && zok && !(wr(px-1, py, pz-1) && wr(px+1, py, pz+1)
                && wr(px+1, py, pz-1) && wr(px-1, py, pz+1))) return 1'b0;
        if (yok && zok && !(wr(px, py-1, pz-1) && wr(px, py+1, pz+1)
                && wr(px, py+1, pz-1) && wr(px, py-1, pz+1))) return 1'b0;
        return 1'b1;
    endfunction

    // expected mean curvature at a voxel, Q25.7 saturated
    function automatic logic [31:0] predict_curvature(int px, int py, int pz);
        bit xok, yok, zok, neg;
        longint c, dx, dy, dz, dxx, dyy, dzz, cxy, cxz, cyz, num;
        longint unsigned s, mag, q1, r, q;
        dx = 0; dy = 0; dz = 0; dxx = 0; dyy = 0; dzz = 0;
        cxy = 0; cxz = 0; cyz = 0;
        xok = px >= 1 && px + 1 < eff_size(sz_x);
        yok = py >= 1 && py + 1 < eff_size(sz_y);
        zok = pz >= 1 && pz + 1 < eff_size(sz_z);
        c = vox(px, py, pz);
        if (xok) begin
            dx  = vox(px-1, py, pz) - vox(px+1, py, pz);
            dxx = vox(px-1, py, pz) - 2 * c + vox(px+1, py, pz);
        end
        if (yok) begin
            dy  = vox(px, py-1, pz) - vox(px, py+1, pz);
            dyy = vox(px, py-1, pz) - 2 * c + vox(px, py+1, pz);
        end
        if (zok) begin
            dz  = vox(px, py, pz-1) - vox(px, py, pz+1);
            dzz = vox(px, py, pz-1) - 2 * c + vox(px, py, pz+1);
        end
        if (xok && yok)
            cxy = vox(px-1, py-1, pz) + vox(px+1, py+1, pz)
                - vox(px+1, py-1, pz) - vox(px-1, py+1, pz);
        if (xok && zok)
            cxz = vox(px-1, py, pz-1) + vox(px+1, py, pz+1)
                - vox(px+1, py, pz-1) - vox(px-1, py, pz+1);
        if (yok && zok)
            cyz = vox(px, py-1, pz-1) + vox(px, py+1, pz+1)
                - vox(px, py+1, pz-1) - vox(px, py-1, pz+1);
        num = 2 * dxx * (dy * dy + dz * dz) + 2 * dyy * (dx * dx + dz * dz)
            + 2 * dzz * (dx * dx + dy * dy)
            - dx * dy * cxy - dx * dz * cxz - dy * dz * cyz;
        s = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        if (s == 0) return 32'd0;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        q1 = mag / s;
        r  = mag % s;
        if (q1 >= (64'd1 << 25)) q = 64'd1 << 32;
        else q = q1 * 128 + (r * 128) / s;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    // send one item in bursts with random gaps; update prediction on acceptance
    task automatic send_item(logic op, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                             logic signed [15:0] v, bit known, logic [31:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        s_level_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (op == OP_WRITE) begin
            level_mem[x + 32 * (y + 32 * z)] = v;
            written[x + 32 * (y + 32 * z)] = 1'b1;
        end else begin
            curv_q.push_back(known ? k : predict_curvature(x, y, z));
        end
    endtask

    // wait until the engine has drained, then let it settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (curv_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [5:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SIZE_X) sz_x = data;
        else if (idx == CFG_SIZE_Y) sz_y = data;
        else if (idx == CFG_SIZE_Z) sz_z = data;
        @(posedge aclk);
    endtask

    task automatic add_row(logic op, int x, int y, int z, int v, bit known);
        stim_row_t r;
        r.op = op; r.x = x[4:0]; r.y = y[4:0]; r.z = z[4:0];
        r.v = v[15:0]; r.known = known; r.k = 32'd0;
        dir_tab.push_back(r);
    endtask

    function automatic logic signed [15:0] rand_level();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    // result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (curv_q.size() == 0) begin
                $error("curvature: unexpected item, actual %h", m_curvature);
                fails++;
            end else begin
                if (m_curvature !== curv_q[0]) begin
                    $error("curvature: expected %h actual %h", curv_q[0], m_curvature);
                    fails++;
                end
                void'(curv_q.pop_front());
            end
        end
    end

    // receiver stall pattern of randomly changing density
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 400 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (cyc > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        int lim_x, lim_y, lim_z;
        logic [5:0] sets [0:5][0:2];
        sets[0] = '{6'd32, 6'd32, 6'd32};
        sets[1] = '{6'd1, 6'd1, 6'd1};
        sets[2] = '{6'd0, 6'd5, 6'd63};
        sets[3] = '{6'd17, 6'd32, 6'd3};
        sets[4] = '{6'd3, 6'd3, 6'd3};
        sets[5] = '{6'd8, 6'd40, 6'd12};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: corners right after reset give zero gradient
        add_row(OP_COMPUTE, 0, 0, 0, 0, 1'b1);
        add_row(OP_COMPUTE, 31, 31, 31, 0, 1'b1);
        add_row(OP_COMPUTE, 0, 31, 0, 0, 1'b1);
        // fill a small corner block that the random computes work in
        for (int i = 0; i < FILL * FILL * FILL; i++)
            add_row(OP_WRITE, i % FILL, (i / FILL) % FILL, i / (FILL * FILL),
                    int'($urandom), 1'b0);
        // extremes around one voxel, then a flat patch
        add_row(OP_WRITE, 1, 2, 2, 32767, 1'b0);
        add_row(OP_WRITE, 3, 2, 2, -32768, 1'b0);
        add_row(OP_WRITE, 2, 1, 2, -32768, 1'b0);
        add_row(OP_WRITE, 2, 3, 2, 32767, 1'b0);
        add_row(OP_WRITE, 2, 2, 1, 32767, 1'b0);
        add_row(OP_WRITE, 2, 2, 3, -32768, 1'b0);
        add_row(OP_WRITE, 2, 2, 2, 0, 1'b0);
        add_row(OP_COMPUTE, 2, 2, 2, 0, 1'b0);
        add_row(OP_WRITE, 3, 3, 3, 256, 1'b0);
        add_row(OP_WRITE, 2, 3, 3, 256, 1'b0);
        add_row(OP_WRITE, 4, 3, 3, 256, 1'b0);
        add_row(OP_WRITE, 3, 2, 3, 256, 1'b0);
        add_row(OP_WRITE, 3, 4, 3, 256, 1'b0);
        add_row(OP_WRITE, 3, 3, 2, 256, 1'b0);
        add_row(OP_WRITE, 3, 3, 4, 256, 1'b0);
        add_row(OP_COMPUTE, 3, 3, 3, 0, 1'b1);
        add_row(OP_COMPUTE, 1, 1, 1, 0, 1'b0);
        add_row(OP_COMPUTE, 4, 4, 4, 0, 1'b0);
        add_row(OP_COMPUTE, 3, 2, 2, 0, 1'b0);
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                      dir_tab[i].v, dir_tab[i].known, dir_tab[i].k);

        // random phases over several size settings
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            cfg_write(CFG_SIZE_X, sets[p][0]);
            cfg_write(CFG_SIZE_Y, sets[p][1]);
            cfg_write(CFG_SIZE_Z, sets[p][2]);
            if (p == 2) cfg_write(CFG_NONE, 6'($urandom));
            lim_x = (eff_size(sz_x) > 0) ? eff_size(sz_x) - 1 : 0;
            lim_y = (eff_size(sz_y) > 0) ? eff_size(sz_y) - 1 : 0;
            lim_z = (eff_size(sz_z) > 0) ? eff_size(sz_z) - 1 : 0;
            n = 0;
            while (n < 52) begin
                logic [4:0] x, y, z;
                if ($urandom_range(0, 4) != 0) begin
                    x = 5'($urandom_range(0, lim_x));
                    y = 5'($urandom_range(0, lim_y));
                    z = 5'($urandom_range(0, lim_z));
                end else begin
                    x = 5'($urandom); y = 5'($urandom); z = 5'($urandom);
                end
                if ($urandom_range(0, 9) < 6) begin
                    // keep computes on voxels whose neighborhood is written
                    if (!legal(x, y, z)) begin
                        x = 5'($urandom_range(1, FILL - 2));
                        y = 5'($urandom_range(1, FILL - 2));
                        z = 5'($urandom_range(1, FILL - 2));
                    end
                    send_item(OP_COMPUTE, x, y, z, 16'($urandom), 1'b0, 32'd0);
                end else begin
                    send_item(OP_WRITE, x, y, z, rand_level(), 1'b0, 32'd0);
                end
                n++;
            end
        end

        wait_idle();
        if (fails == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
